FILE: rtl/cpo_pkg.sv
// ----------------------------------------------------------------------------
// Convex polygon overlap test package
// Request command codes and the control group for the shared dot product unit.
// ----------------------------------------------------------------------------
package cpo_pkg;

  // Request commands.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  // Steps of the shared dot product unit, one per cycle.
  typedef struct packed {
    logic mul_x;
    logic mul_y;
    logic add;
  } dot_ctrl_t;

endpackage

FILE: rtl/convex_polygon_overlap_test.sv
// ----------------------------------------------------------------------------
// Convex polygon overlap test
// Separating-axis overlap test of two convex polygons held in a vertex store.
// Clear and load requests are taken back to back.
// A test with both polygons active and non-empty projects every vertex of
// both polygons onto the normal of each edge in turn and ends early on the
// first separating axis; each vertex projection steps through the read, the
// x and y products, the sum and the interval update on the single shared
// multiplier. Other tests go straight to the result; out_stall can hold it.
// Reset clears both counts, the dropped flag and the sequencer.
// ----------------------------------------------------------------------------
module convex_polygon_overlap_test
  import cpo_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        polygon_select,
  input  logic [15:0] vertex_x,
  input  logic [15:0] vertex_y,
  input  logic        first_active,
  input  logic        second_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        overlapping,
  output logic        overflowed
);

  localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int AW   = CW + 1;
  localparam int DW   = 2 * CW + 2;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EA   = 4'd1;
  localparam logic [3:0] S_EB   = 4'd2;
  localparam logic [3:0] S_AX   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_MX   = 4'd5;
  localparam logic [3:0] S_MY   = 4'd6;
  localparam logic [3:0] S_AD   = 4'd7;
  localparam logic [3:0] S_CP   = 4'd8;
  localparam logic [3:0] S_CK   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]           state;
  logic                 src;
  logic                 pp;
  logic [IW-1:0]        e;
  logic [IW-1:0]        i;
  logic signed [CW-1:0] ex;
  logic signed [CW-1:0] ey;
  logic signed [AW-1:0] ax;
  logic signed [AW-1:0] ay;
  logic signed [DW-1:0] lo_a;
  logic signed [DW-1:0] hi_a;
  logic signed [DW-1:0] lo_b;
  logic signed [DW-1:0] hi_b;
  logic                 result;

  logic                 accept;
  logic                 st_clear;
  logic                 st_load;
  logic                 rd_en;
  logic                 rd_poly;
  logic [IW-1:0]        rd_idx;
  logic signed [CW-1:0] rd_x;
  logic signed [CW-1:0] rd_y;
  logic [CNTW-1:0]      count0;
  logic [CNTW-1:0]      count1;
  logic                 dropped;
  logic [CNTW-1:0]      n_src;
  logic [CNTW-1:0]      n_cur;
  logic                 e_last;
  logic                 i_last;
  logic [IW-1:0]        f_idx;
  dot_ctrl_t            dctrl;
  logic signed [CW-1:0] d_coord;
  logic signed [AW-1:0] d_axis;
  logic signed [DW-1:0] dot;
  logic signed [DW-1:0] sel_lo;
  logic signed [DW-1:0] sel_hi;
  logic signed [DW-1:0] lo_new;
  logic signed [DW-1:0] hi_new;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign st_clear = accept && (command == CMD_CLEAR);
  assign st_load  = accept && (command == CMD_LOAD);
  assign out_free = !out_valid || !out_stall;

  cpo_vertex_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .CW           (CW),
    .IW           (IW),
    .CNTW         (CNTW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .clear     (st_clear),
    .load      (st_load),
    .load_poly (polygon_select),
    .load_x    (vertex_x[CW-1:0]),
    .load_y    (vertex_y[CW-1:0]),
    .rd_en     (rd_en),
    .rd_poly   (rd_poly),
    .rd_idx    (rd_idx),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .count0    (count0),
    .count1    (count1),
    .dropped   (dropped)
  );

  // Edge and vertex bookkeeping.
  assign n_src  = src ? count1 : count0;
  assign n_cur  = (src ^ pp) ? count1 : count0;
  assign e_last = (CNTW'(e) + CNTW'(1)) == n_src;
  assign i_last = (CNTW'(i) + CNTW'(1)) == n_cur;
  assign f_idx  = e_last ? '0 : e + IW'(1);

  // Vertex read address for each sequencer step.
  always_comb begin
    rd_en   = 1'b0;
    rd_poly = src;
    rd_idx  = e;
    unique case (state)
      S_EA: begin
        rd_en = 1'b1;
      end
      S_EB: begin
        rd_en  = 1'b1;
        rd_idx = f_idx;
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_poly = src ^ pp;
        rd_idx  = i;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Dot product unit steps and operands.
  always_comb begin
    dctrl.mul_x = (state == S_MX);
    dctrl.mul_y = (state == S_MY);
    dctrl.add   = (state == S_AD);
    d_coord     = (state == S_MY) ? rd_y : rd_x;
    d_axis      = (state == S_MY) ? ay : ax;
  end

  cpo_dot_unit #(
    .CW (CW)
  ) u_dot (
    .clk   (clk),
    .ctrl  (dctrl),
    .coord (d_coord),
    .axis  (d_axis),
    .dot   (dot)
  );

  // Running projection interval of the polygon being projected.
  assign sel_lo = pp ? lo_b : lo_a;
  assign sel_hi = pp ? hi_b : hi_a;
  assign lo_new = ((i == '0) || (dot < sel_lo)) ? dot : sel_lo;
  assign hi_new = ((i == '0) || (dot > sel_hi)) ? dot : sel_hi;

  // Result valid: set when a verdict is handed over, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (command == CMD_TEST)) begin
            src <= 1'b0;
            e   <= '0;
            if (!(first_active && second_active)) begin
              result <= 1'b0;
              state  <= S_DONE;
            end else if ((count0 == '0) || (count1 == '0)) begin
              // An empty polygon is separated from a non-empty one.
              result <= (count0 == '0) && (count1 == '0);
              state  <= S_DONE;
            end else begin
              state <= S_EA;
            end
          end
        end
        S_EA: begin
          state <= S_EB;
        end
        S_EB: begin
          ex    <= rd_x;
          ey    <= rd_y;
          state <= S_AX;
        end
        S_AX: begin
          // Edge normal: (-(yf - ye), xf - xe).
          ax    <= AW'(ey) - AW'(rd_y);
          ay    <= AW'(rd_x) - AW'(ex);
          i     <= '0;
          pp    <= 1'b0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_MX;
        end
        S_MX: begin
          state <= S_MY;
        end
        S_MY: begin
          state <= S_AD;
        end
        S_AD: begin
          state <= S_CP;
        end
        S_CP: begin
          if (pp) begin
            lo_b <= lo_new;
            hi_b <= hi_new;
          end else begin
            lo_a <= lo_new;
            hi_a <= hi_new;
          end
          if (i_last) begin
            i <= '0;
            if (pp) begin
              state <= S_CK;
            end else begin
              pp    <= 1'b1;
              state <= S_RD;
            end
          end else begin
            i     <= i + IW'(1);
            state <= S_RD;
          end
        end
        S_CK: begin
          // Disjoint intervals on this axis separate the polygons.
          if (!((hi_b >= lo_a) && (hi_a >= lo_b))) begin
            result <= 1'b0;
            state  <= S_DONE;
          end else if (e_last) begin
            if (src) begin
              result <= 1'b1;
              state  <= S_DONE;
            end else begin
              src   <= 1'b1;
              e     <= '0;
              state <= S_EA;
            end
          end else begin
            e     <= e + IW'(1);
            state <= S_EA;
          end
        end
        S_DONE: begin
          if (out_free) begin
            overlapping <= result;
            overflowed  <= dropped;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cpo_vertex_store.sv
// ----------------------------------------------------------------------------
// Vertex store
// Holds the vertex lists and counts of both polygons and the dropped flag.
// One write port for loads, one registered read port for the sequencer.
// ----------------------------------------------------------------------------
module cpo_vertex_store #(
  parameter int MAX_VERTICES = 16,
  parameter int CW           = 16,
  parameter int IW           = 4,
  parameter int CNTW         = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 load,
  input  logic                 load_poly,
  input  logic [CW-1:0]        load_x,
  input  logic [CW-1:0]        load_y,
  input  logic                 rd_en,
  input  logic                 rd_poly,
  input  logic [IW-1:0]        rd_idx,
  output logic signed [CW-1:0] rd_x,
  output logic signed [CW-1:0] rd_y,
  output logic [CNTW-1:0]      count0,
  output logic [CNTW-1:0]      count1,
  output logic                 dropped
);

  logic [2*CW-1:0] mem [2][MAX_VERTICES];
  logic [CNTW-1:0] count [2];
  logic [CNTW-1:0] sel_count;
  logic            has_room;

  assign sel_count = load_poly ? count[1] : count[0];
  assign has_room  = (sel_count < CNTW'(MAX_VERTICES));
  assign count0    = count[0];
  assign count1    = count[1];

  // Counts and the dropped flag.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count[0] <= '0;
      count[1] <= '0;
      dropped  <= 1'b0;
    end else if (load) begin
      if (has_room) begin
        count[load_poly] <= sel_count + CNTW'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // Vertex memory write; a full polygon drops the vertex.
  always_ff @(posedge clk) begin
    if (load && has_room) begin
      mem[load_poly][sel_count[IW-1:0]] <= {load_x, load_y};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_x, rd_y} <= mem[rd_poly][rd_idx];
    end
  end

endmodule

FILE: rtl/cpo_dot_unit.sv
// ----------------------------------------------------------------------------
// Shared dot product unit
// One signed multiplier and one adder, stepped by the sequencer: x times the
// axis x, then y times the axis y, then the sum of both products.
// ----------------------------------------------------------------------------
module cpo_dot_unit
  import cpo_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                     clk,
  input  dot_ctrl_t                ctrl,
  input  logic signed [CW-1:0]     coord,
  input  logic signed [CW:0]       axis,
  output logic signed [2*CW+1:0]   dot
);

  localparam int PW = 2 * CW + 1;
  localparam int DW = 2 * CW + 2;

  logic signed [PW-1:0] mult;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] part;

  assign mult = PW'(coord) * PW'(axis);

  // Product register, the held x product, and the final sum.
  always_ff @(posedge clk) begin
    if (ctrl.mul_x) begin
      prod <= mult;
    end
    if (ctrl.mul_y) begin
      prod <= mult;
      part <= prod;
    end
    if (ctrl.add) begin
      dot <= DW'(part) + DW'(prod);
    end
  end

endmodule

FILE: tb/sv/polygon_overlap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon overlap checker
// Watches the request and result channels of the overlap tester. It keeps its
// own vertex lists and dropped flag, predicts the verdict of every accepted
// test request and compares each accepted result, in order, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module polygon_overlap_checker
  import cpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic        polygon_select,
  input  logic [15:0] vertex_x,
  input  logic [15:0] vertex_y,
  input  logic        first_active,
  input  logic        second_active,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        overlapping,
  input  logic        overflowed,
  output int          mismatches,
  output int          awaited
);

  localparam int MAX_VERTS = 16;

  typedef struct packed {
    logic overlapping;
    logic overflowed;
  } verdict_t;

  // Vertex lists of both polygons, indexed by polygon then by vertex.
  logic signed [15:0] shape_x [2][MAX_VERTS];
  logic signed [15:0] shape_y [2][MAX_VERTS];
  int                 shape_count [2];
  logic               dropped;
  verdict_t           verdict_q [$];
  int                 fail_total = 0;

  // Projects every vertex of one polygon onto an axis and returns the interval.
  function automatic void project_shape(input int s, input longint ax, input longint ay,
                                        output longint lo, output longint hi);
    longint q;
    lo = 0;
    hi = 0;
    for (int i = 0; i < shape_count[s]; i++) begin
      q = longint'(shape_x[s][i]) * ax + longint'(shape_y[s][i]) * ay;
      if (i == 0 || q < lo) lo = q;
      if (i == 0 || q > hi) hi = q;
    end
  endfunction

  // True when some edge normal of polygon a splits the two polygons apart.
  // An empty partner is always split off by the first axis.
  function automatic logic axes_separate(input int a);
    int     b;
    int     n;
    int     f;
    longint ax;
    longint ay;
    longint lo_a;
    longint hi_a;
    longint lo_b;
    longint hi_b;
    b = 1 - a;
    n = shape_count[a];
    for (int e = 0; e < n; e++) begin
      f  = (e + 1 == n) ? 0 : e + 1;
      ax = longint'(shape_y[a][e]) - longint'(shape_y[a][f]);
      ay = longint'(shape_x[a][f]) - longint'(shape_x[a][e]);
      if (shape_count[b] == 0) return 1'b1;
      project_shape(a, ax, ay, lo_a, hi_a);
      project_shape(b, ax, ay, lo_b, hi_b);
      if (!(hi_b >= lo_a && hi_a >= lo_b)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare results first, then fold the accepted request into the state.
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      shape_count[0] = 0;
      shape_count[1] = 0;
      dropped = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual overlapping=%0b overflowed=%0b",
                   $time, overlapping, overflowed);
          fail_total++;
        end else begin
          want = verdict_q.pop_front();
          if (overlapping !== want.overlapping) begin
            $display("%0t: overlapping mismatch, expected %0b actual %0b",
                     $time, want.overlapping, overlapping);
            fail_total++;
          end
          if (overflowed !== want.overflowed) begin
            $display("%0t: overflowed mismatch, expected %0b actual %0b",
                     $time, want.overflowed, overflowed);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (command)
          CMD_CLEAR: begin
            shape_count[0] = 0;
            shape_count[1] = 0;
            dropped = 1'b0;
          end
          CMD_LOAD: begin
            // A full polygon drops the vertex and remembers that it did.
            if (shape_count[polygon_select] < MAX_VERTS) begin
              shape_x[polygon_select][shape_count[polygon_select]] = vertex_x;
              shape_y[polygon_select][shape_count[polygon_select]] = vertex_y;
              shape_count[polygon_select]++;
            end else begin
              dropped = 1'b1;
            end
          end
          CMD_TEST: begin
            want.overlapping = first_active && second_active &&
                               !axes_separate(0) && !axes_separate(1);
            want.overflowed  = dropped;
            verdict_q.push_back(want);
          end
          default: begin
          end
        endcase
      end
    end
    mismatches <= fail_total;
    awaited    <= verdict_q.size();
  end

endmodule

FILE: tb/sv/convex_polygon_overlap_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon overlap test bench
// Drives clear, load and test requests into the overlap tester: a directed
// opening on extreme coordinates, empty, single-point and degenerate polygons,
// then random pairs of convex polygons placed near each other, with overflow,
// inactive polygons and random noise mixed in. Both channels idle at random.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module convex_polygon_overlap_test_tb;
  import cpo_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int SETTLE_CYCLES   = 40;
  localparam int VERT_CAP        = 16;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } corner_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic        polygon_select;
  logic [15:0] vertex_x;
  logic [15:0] vertex_y;
  logic        first_active;
  logic        second_active;
  logic        out_valid;
  logic        out_stall;
  logic        overlapping;
  logic        overflowed;

  int          mismatches;
  int          awaited;
  int          requests_sent = 0;
  logic        back_to_back = 1'b0;
  corner_t     first_corners [$];
  corner_t     second_corners [$];

  always #5 clk = ~clk;

  convex_polygon_overlap_test u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .polygon_select (polygon_select),
    .vertex_x       (vertex_x),
    .vertex_y       (vertex_y),
    .first_active   (first_active),
    .second_active  (second_active),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .overlapping    (overlapping),
    .overflowed     (overflowed)
  );

  polygon_overlap_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .polygon_select (polygon_select),
    .vertex_x       (vertex_x),
    .vertex_y       (vertex_y),
    .first_active   (first_active),
    .second_active  (second_active),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .overlapping    (overlapping),
    .overflowed     (overflowed),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  function automatic logic rand_bit();
    return logic'($urandom_range(0, 1));
  endfunction

  // Mostly short gaps, a few long ones, none at all in back-to-back stretches.
  function automatic int idle_gap();
    int r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Cosine of sixteen evenly spaced directions, scaled by 100.
  function automatic int ring_cos(input int k);
    case (k)
      0:       return 100;
      1, 15:   return 92;
      2, 14:   return 71;
      3, 13:   return 38;
      4, 12:   return 0;
      5, 11:   return -38;
      6, 10:   return -71;
      7, 9:    return -92;
      default: return -100;
    endcase
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Polygon sizes: mostly small, a few large, now and then past capacity.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return $urandom_range(0, 2);
    if (r < 88) return $urandom_range(3, 6);
    if (r < 95) return $urandom_range(7, VERT_CAP);
    return $urandom_range(VERT_CAP + 1, VERT_CAP + 3);
  endfunction

  function automatic int pick_radius();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 3);
    return $urandom_range(20, 12000);
  endfunction

  // Presents one request after a random gap and holds it until accepted.
  task automatic send_request(input logic [1:0] cmd, input logic sel,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic fa, input logic sa);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= cmd;
    polygon_select <= sel;
    vertex_x       <= x;
    vertex_y       <= y;
    first_active   <= fa;
    second_active  <= sa;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // Holds off new requests until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Builds a convex polygon from a random subset of ring directions around a
  // center; sizes past capacity get random extra vertices that will be dropped.
  task automatic build_shape(input logic sel, input int cx, input int cy,
                             input int radius, input int count);
    logic [15:0] mask;
    int          picked;
    int          k;
    logic        reverse;
    corner_t     c;
    mask   = '0;
    picked = 0;
    while (picked < count && picked < VERT_CAP) begin
      k = $urandom_range(0, 15);
      if (!mask[k]) begin
        mask[k] = 1'b1;
        picked++;
      end
    end
    reverse = rand_bit();
    for (int i = 0; i < 16; i++) begin
      k = reverse ? 15 - i : i;
      if (mask[k]) begin
        c.x = clamp16(cx + ring_cos(k) * radius / 100);
        c.y = clamp16(cy + ring_cos((k + 12) % 16) * radius / 100);
        if (sel) second_corners.push_back(c);
        else first_corners.push_back(c);
      end
    end
    for (int i = VERT_CAP; i < count; i++) begin
      c = corner_t'($urandom);
      if (sel) second_corners.push_back(c);
      else first_corners.push_back(c);
    end
  endtask

  // One well-formed round: usually a clear, load two nearby polygons with the vertex
  // order interleaved between them, run a few tests, sometimes add noise.
  task automatic run_sequence();
    int      cx;
    int      cy;
    int      r_first;
    int      r_second;
    int      span;
    int      tests;
    logic    fa;
    logic    sa;
    corner_t c;
    back_to_back = ($urandom_range(0, 6) == 0);
    if ($urandom_range(0, 9) != 0)
      send_request(CMD_CLEAR, rand_bit(), 16'($urandom), 16'($urandom), rand_bit(),
                   rand_bit());
    r_first  = pick_radius();
    r_second = pick_radius();
    cx   = int'($urandom_range(0, 16000)) - 8000;
    cy   = int'($urandom_range(0, 16000)) - 8000;
    span = (r_first + r_second) * 13 / 10 + 1;
    build_shape(1'b0, cx, cy, r_first, pick_size());
    build_shape(1'b1, cx + int'($urandom_range(0, 2 * span)) - span,
                cy + int'($urandom_range(0, 2 * span)) - span, r_second, pick_size());
    while (first_corners.size() + second_corners.size() > 0) begin
      if (second_corners.size() == 0 || (first_corners.size() != 0 && rand_bit())) begin
        c = first_corners.pop_front();
        send_request(CMD_LOAD, 1'b0, c.x, c.y, rand_bit(), rand_bit());
      end else begin
        c = second_corners.pop_front();
        send_request(CMD_LOAD, 1'b1, c.x, c.y, rand_bit(), rand_bit());
      end
    end
    tests = $urandom_range(1, 3);
    repeat (tests) begin
      fa = 1'b1;
      sa = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        fa = rand_bit();
        sa = rand_bit();
      end
      send_request(CMD_TEST, rand_bit(), 16'($urandom), 16'($urandom), fa, sa);
    end
    // Noise: arbitrary requests with every field random.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4))
        send_request(2'($urandom_range(0, 3)), rand_bit(), 16'($urandom), 16'($urandom),
                     rand_bit(), rand_bit());
    end
    back_to_back = 1'b0;
  endtask

  // Result side: open stretches of random length, some long, between stalls.
  initial begin
    int open_len;
    int stall_len;
    forever begin
      open_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 8);
      stall_len = $urandom_range(0, 99);
      if (stall_len < 40) stall_len = 0;
      else if (stall_len < 95) stall_len = $urandom_range(1, 4);
      else stall_len = $urandom_range(10, 60);
      out_stall <= 1'b0;
      repeat (open_len) @(posedge clk);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Request side and verdict.
  initial begin
    int directed_total;
    int rounds;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    command        <= CMD_CLEAR;
    polygon_select <= 1'b0;
    vertex_x       <= '0;
    vertex_y       <= '0;
    first_active   <= 1'b0;
    second_active  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty polygons, inactive combinations and the unused command.
    send_request(CMD_CLEAR, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(CMD_TEST, 1'b1, 16'hffff, 16'hffff, 1'b0, 1'b1);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_UNUSED, 1'b1, 16'hffff, 16'hffff, 1'b1, 1'b1);
    // Single points at opposite corners: one against empty, then point to point.
    send_request(CMD_LOAD, 1'b0, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(CMD_LOAD, 1'b1, 16'h8000, 16'h8000, 1'b1, 1'b1);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    // Extreme triangle against a segment, then a repeated vertex.
    send_request(CMD_LOAD, 1'b0, 16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_request(CMD_LOAD, 1'b0, 16'h7fff, 16'h8000, 1'b0, 1'b0);
    send_request(CMD_LOAD, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(CMD_LOAD, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_LOAD, 1'b1, 16'h8000, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_request(CMD_CLEAR, 1'b1, 16'hffff, 16'hffff, 1'b1, 1'b1);
    send_request(CMD_TEST, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1);
    drain_results();
    directed_total = requests_sent;

    // Random rounds, draining now and then so the block runs dry mid-stream.
    rounds = 0;
    while (requests_sent < directed_total + RANDOM_REQUESTS) begin
      run_sequence();
      rounds++;
      if (rounds % 8 == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #200000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
